@@ src/somcm_pkg.sv @@
// Package for the SOM color map trainer: command codes, controller states,
// blend weight table and the controller/datapath command and status structs.
// No dependencies.
package somcm_pkg;

  localparam int MapWidthDefault  = 20;
  localparam int MapHeightDefault = 20;
  localparam logic [3:0] RadiusReset = 4'd10;
  localparam int GaussLen = 38;

  typedef enum logic [1:0] {
    CMD_TRAIN = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_UPD_START,
    ST_UPD_RD,
    ST_UPD_WAIT,
    ST_UPD_WR,
    ST_READ_WAIT,
    ST_OUT
  } state_t;

  // Gaussian weight in Q0.16 over squared distance; zero past the table.
  function automatic logic [12:0] gauss_q16(input logic [10:0] d2);
    logic [12:0] g;
    begin
      unique case (d2)
        11'd0:  g = 13'd5215;
        11'd1:  g = 13'd4062;
        11'd2:  g = 13'd3163;
        11'd3:  g = 13'd2463;
        11'd4:  g = 13'd1919;
        11'd5:  g = 13'd1494;
        11'd6:  g = 13'd1164;
        11'd7:  g = 13'd906;
        11'd8:  g = 13'd706;
        11'd9:  g = 13'd550;
        11'd10: g = 13'd428;
        11'd11: g = 13'd333;
        11'd12: g = 13'd260;
        11'd13: g = 13'd202;
        11'd14: g = 13'd157;
        11'd15: g = 13'd123;
        11'd16: g = 13'd96;
        11'd17: g = 13'd74;
        11'd18: g = 13'd58;
        11'd19: g = 13'd45;
        11'd20: g = 13'd35;
        11'd21: g = 13'd27;
        11'd22: g = 13'd21;
        11'd23: g = 13'd17;
        11'd24: g = 13'd13;
        11'd25: g = 13'd10;
        11'd26: g = 13'd8;
        11'd27: g = 13'd6;
        11'd28: g = 13'd5;
        11'd29: g = 13'd4;
        11'd30: g = 13'd3;
        11'd31: g = 13'd2;
        11'd32: g = 13'd2;
        11'd33, 11'd34, 11'd35, 11'd36, 11'd37: g = 13'd1;
        default: g = 13'd0;
      endcase
      return g;
    end
  endfunction

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_start; // clear scan position and found flag
    logic scan_step;  // issue next scan read
    logic upd_start;  // set neighborhood window from winner
    logic upd_rd;     // issue read of current neighborhood entry
    logic upd_wr;     // write blended entry and advance
    logic entry_wr;   // write the captured entry
    logic entry_rd;   // read the captured entry
    logic out_load;   // build the result register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // last scan read issued
    logic upd_last;   // last neighborhood entry is current
    logic in_range;   // captured entry coordinates are on the map
    cmd_t cmd;
  } dp_status_t;

endpackage

@@ src/som_color_map_trainer.sv @@
// Top level of the SOM color map trainer: joins controller, dispatch and
// datapath. Depends on somcm_pkg, somcm_ctrl, somcm_disp, somcm_dp.
//
//  channel  | signals                                      | handshake
//  ---------+----------------------------------------------+--------------------
//  input    | command entry_x entry_y red green blue       | in_valid/in_ready
//  output   | winner_x winner_y out_red out_green out_blue | out_valid/out_ready
//  config   | neighbour_radius_data                        | neighbour_radius_we
//
// Write and no-op go through capture, dispatch and result states; read adds a
// memory wait before the result. Train scans the map at one memory read a
// cycle, drains, sets up the window, then reads, weights and writes each entry
// of the clipped neighborhood square in turn.
// Reset sets radius to 10; map contents are undefined until written.
// One result register: a new item transfers while a result waits, and its
// own result then holds until the waiting one transfers.
module som_color_map_trainer #(
  parameter int MAP_WIDTH  = somcm_pkg::MapWidthDefault,
  parameter int MAP_HEIGHT = somcm_pkg::MapHeightDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [4:0] entry_x,
  input  logic [4:0] entry_y,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] winner_x,
  output logic [4:0] winner_y,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  input  logic       neighbour_radius_we,
  input  logic [3:0] neighbour_radius_data
);
  import somcm_pkg::*;

  dp_cmd_t    dcmd;
  dp_status_t status;
  logic go_scan, go_write, go_read, go_out;

  somcm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .go_scan, .go_write, .go_read, .go_out,
    .status, .cmd(dcmd)
  );

  somcm_disp u_disp (
    .clk, .rst, .loaded(dcmd.load), .status,
    .go_scan, .go_write, .go_read, .go_out
  );

  somcm_dp #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_dp (
    .clk, .rst, .cmd(dcmd),
    .cfg_we(neighbour_radius_we), .cfg_data(neighbour_radius_data),
    .command, .entry_x, .entry_y, .red, .green, .blue,
    .status, .winner_x, .winner_y, .out_red, .out_green, .out_blue
  );

  // An accepted item closes the input until it is done.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input open right after transfer");
  // A waiting result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(winner_x) && $stable(winner_y)
      && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("result changed while waiting");
  // Output valid is always known.
  assert property (@(posedge clk) disable iff (rst) !$isunknown(out_valid))
    else $error("out_valid unknown");
endmodule

@@ src/somcm_ctrl.sv @@
// Controller for the SOM color map trainer: sequences scan, update, read
// and write. Depends on somcm_pkg.
module somcm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   go_scan,
  input  logic                   go_write,
  input  logic                   go_read,
  input  logic                   go_out,
  input  somcm_pkg::dp_status_t  status,
  output somcm_pkg::dp_cmd_t     cmd
);
  import somcm_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // Hold the result until transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (in_valid) state_next = ST_DISP;
      ST_DISP: begin
        priority if (go_scan)           state_next = ST_SCAN;
        else if (go_read)               state_next = ST_READ_WAIT;
        else if (go_write || go_out)    state_next = ST_OUT;
      end
      ST_SCAN:       if (status.scan_last) state_next = ST_SCAN_DRAIN;
      ST_SCAN_DRAIN: state_next = ST_UPD_START;
      ST_UPD_START:  state_next = ST_UPD_RD;
      ST_UPD_RD:     state_next = ST_UPD_WAIT;
      ST_UPD_WAIT:   state_next = ST_UPD_WR;
      ST_UPD_WR:     state_next = status.upd_last ? ST_OUT : ST_UPD_RD;
      ST_READ_WAIT:  state_next = ST_OUT;
      ST_OUT:        if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE:       cmd.load = in_valid;
      ST_DISP: begin
        cmd.scan_start = go_scan;
        cmd.entry_wr   = go_write;
        cmd.entry_rd   = go_read;
      end
      ST_SCAN:       cmd.scan_step = 1'b1;
      ST_SCAN_DRAIN: ;
      ST_UPD_START:  cmd.upd_start = 1'b1;
      ST_UPD_RD:     cmd.upd_rd = 1'b1;
      ST_UPD_WAIT:   ;
      ST_UPD_WR:     cmd.upd_wr = 1'b1;
      ST_READ_WAIT:  ;
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ src/somcm_disp.sv @@
// Dispatch stage: after an item is captured, routes it to scan, write, read
// or straight to the result. Depends on somcm_pkg.
module somcm_disp (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  loaded,
  input  somcm_pkg::dp_status_t status,
  output logic                  go_scan,
  output logic                  go_write,
  output logic                  go_read,
  output logic                  go_out
);
  import somcm_pkg::*;

  logic pend;

  // Mark a captured item for one dispatch cycle.
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else     pend <= loaded;
  end

  always_comb begin
    go_scan  = 1'b0;
    go_write = 1'b0;
    go_read  = 1'b0;
    go_out   = 1'b0;
    if (pend) begin
      unique case (status.cmd)
        CMD_TRAIN: go_scan  = 1'b1;
        CMD_WRITE: go_write = 1'b1;
        CMD_READ: begin
          go_read = status.in_range;
          go_out  = !status.in_range;
        end
        CMD_NOP:   go_out   = 1'b1;
        default:   go_out   = 1'b1;
      endcase
    end
  end
endmodule

@@ src/somcm_dp.sv @@
// Datapath for the SOM color map trainer: weight memory, distance and
// winner search, neighborhood blend. Depends on somcm_pkg.
module somcm_dp #(
  parameter int MAP_WIDTH  = somcm_pkg::MapWidthDefault,
  parameter int MAP_HEIGHT = somcm_pkg::MapHeightDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  somcm_pkg::dp_cmd_t    cmd,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_data,
  input  logic [1:0]            command,
  input  logic [4:0]            entry_x,
  input  logic [4:0]            entry_y,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output somcm_pkg::dp_status_t status,
  output logic [4:0]            winner_x,
  output logic [4:0]            winner_y,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue
);
  import somcm_pkg::*;

  localparam int Depth = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(MAP_WIDTH);
  localparam int YW    = $clog2(MAP_HEIGHT);

  logic [23:0] mem [Depth];
  logic [23:0] rdata;

  logic [3:0]  radius;
  cmd_t        c_cmd;
  logic [4:0]  c_x, c_y;
  logic [7:0]  c_r, c_g, c_b;

  // Scan position (issue side) and the registered compare side.
  logic [XW-1:0] sx, px;
  logic [YW-1:0] sy, py;
  logic          pv;
  logic [17:0]   best;
  logic          found;
  logic [XW-1:0] wx;
  logic [YW-1:0] wy;

  // Neighborhood window.
  logic [XW-1:0] ux, ux0, ux1;
  logic [YW-1:0] uy, uy1;
  logic [12:0]   gw;

  logic [AW-1:0] raddr, waddr;
  logic [23:0]   wdata;
  logic          we, re;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst)         radius <= RadiusReset;
    else if (cfg_we) radius <= cfg_data;
  end

  // Capture the input item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd <= cmd_t'(command);
      c_x <= entry_x; c_y <= entry_y;
      c_r <= red; c_g <= green; c_b <= blue;
    end
  end

  logic in_range;
  assign in_range = ({2'b0, c_x} < 7'(MAP_WIDTH)) && ({2'b0, c_y} < 7'(MAP_HEIGHT));
  assign status.in_range = in_range;
  assign status.cmd      = c_cmd;
  assign status.scan_last = (sx == XW'(MAP_WIDTH - 1)) && (sy == YW'(MAP_HEIGHT - 1));
  assign status.upd_last  = (ux == ux1) && (uy == uy1);

  // Memory port select.
  always_comb begin
    re = cmd.scan_step || cmd.upd_rd || cmd.entry_rd;
    raddr = '0;
    if (cmd.scan_step)     raddr = AW'(sy * MAP_WIDTH + sx);
    else if (cmd.upd_rd)   raddr = AW'(uy * MAP_WIDTH + ux);
    else                   raddr = AW'(c_y * MAP_WIDTH + c_x);
    we = cmd.upd_wr || (cmd.entry_wr && in_range);
    waddr = cmd.upd_wr ? AW'(uy * MAP_WIDTH + ux) : AW'(c_y * MAP_WIDTH + c_x);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Squared distance of the registered read data.
  function automatic logic [15:0] sqd(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    begin
      d = (a > b) ? a - b : b - a;
      return 16'(d * d);
    end
  endfunction

  logic [17:0] sq_dist;
  assign sq_dist = 18'(sqd(c_r, rdata[23:16])) + 18'(sqd(c_g, rdata[15:8]))
                 + 18'(sqd(c_b, rdata[7:0]));

  // Advance the scan and track the first minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= cmd.scan_step;
    end
    if (cmd.scan_start) begin
      sx <= '0; sy <= '0; found <= 1'b0;
    end else if (cmd.scan_step) begin
      px <= sx; py <= sy;
      if (sx == XW'(MAP_WIDTH - 1)) begin
        sx <= '0; sy <= sy + 1'b1;
      end else begin
        sx <= sx + 1'b1;
      end
    end
    if (pv && (!found || sq_dist < best)) begin
      best <= sq_dist; wx <= px; wy <= py; found <= 1'b1;
    end
  end

  // Window bounds from winner and radius.
  logic [6:0] lx, ly, hx, hy;
  always_comb begin
    lx = 7'(wx) - 7'(radius);
    ly = 7'(wy) - 7'(radius);
    hx = 7'(wx) + 7'(radius);
    hy = 7'(wy) + 7'(radius);
  end

  // Squared offset from the winner of the current entry.
  logic [5:0]  adx, ady;
  logic [10:0] d2;
  always_comb begin
    adx = (ux > wx) ? 6'(ux - wx) : 6'(wx - ux);
    ady = (uy > wy) ? 6'(uy - wy) : 6'(wy - uy);
    d2  = 11'(adx * adx) + 11'(ady * ady);
  end

  // Walk the window.
  always_ff @(posedge clk) begin
    if (cmd.upd_start) begin
      ux0 <= lx[6] ? '0 : XW'(lx);
      ux  <= lx[6] ? '0 : XW'(lx);
      uy  <= ly[6] ? '0 : YW'(ly);
      ux1 <= (hx > 7'(MAP_WIDTH - 1)) ? XW'(MAP_WIDTH - 1) : XW'(hx);
      uy1 <= (hy > 7'(MAP_HEIGHT - 1)) ? YW'(MAP_HEIGHT - 1) : YW'(hy);
    end else if (cmd.upd_wr) begin
      if (ux == ux1) begin
        ux <= ux0; uy <= uy + 1'b1;
      end else begin
        ux <= ux + 1'b1;
      end
    end
    if (cmd.upd_rd) gw <= gauss_q16(d2);
  end

  // Blend toward the color.
  function automatic logic [7:0] blend(input logic [12:0] g, input logic [7:0] c,
                                       input logic [7:0] s);
    logic [24:0] v;
    begin
      v = 25'(g * c) + 25'((17'd65536 - 17'(g)) * s);
      return v[23:16];
    end
  endfunction

  always_comb begin
    if (cmd.upd_wr)
      wdata = {blend(gw, c_r, rdata[23:16]), blend(gw, c_g, rdata[15:8]),
               blend(gw, c_b, rdata[7:0])};
    else
      wdata = {c_r, c_g, c_b};
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      winner_x <= '0; winner_y <= '0;
      out_red <= '0; out_green <= '0; out_blue <= '0;
      if (c_cmd == CMD_TRAIN) begin
        winner_x <= 5'(wx); winner_y <= 5'(wy);
      end else if (c_cmd == CMD_READ && in_range) begin
        out_red <= rdata[23:16]; out_green <= rdata[15:8]; out_blue <= rdata[7:0];
      end
    end
  end

  // Scan never runs past the map.
  assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> ({1'b0, sx} < (XW+1)'(MAP_WIDTH)) && ({1'b0, sy} < (YW+1)'(MAP_HEIGHT)))
    else $error("scan position off map");
  // Neighborhood writes stay on the map.
  assert property (@(posedge clk) disable iff (rst)
    cmd.upd_wr |-> ({1'b0, ux} < (XW+1)'(MAP_WIDTH)) && ({1'b0, uy} < (YW+1)'(MAP_HEIGHT)))
    else $error("update position off map");
  // A scan and an update never overlap.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan_step && (cmd.upd_rd || cmd.upd_wr)))
    else $error("scan and update overlap");
endmodule
